FILE: sv/vme_pkg.sv
// Package for the 3D mask erosion block: shared types, codes and constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package vme_pkg;

  localparam int unsigned DEF_MAX_X   = 64;
  localparam int unsigned DEF_MAX_Y   = 64;
  localparam int unsigned DEF_MAX_Z   = 64;
  localparam int unsigned SIZE_W      = 7;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned NB          = 6;

  localparam logic [SIZE_W-1:0] RST_SIZE_X = 7'd40;
  localparam logic [SIZE_W-1:0] RST_SIZE_Y = 7'd40;
  localparam logic [SIZE_W-1:0] RST_SIZE_Z = 7'd27;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  // Neighbor slots: -x, +x, -y, +y, -z, +z.
  localparam int unsigned NB_XM = 0;
  localparam int unsigned NB_XP = 1;
  localparam int unsigned NB_YM = 2;
  localparam int unsigned NB_YP = 3;
  localparam int unsigned NB_ZM = 4;
  localparam int unsigned NB_ZP = 5;

  typedef struct packed {
    logic signed [31:0] value;
    logic [NB-1:0]      nb_zero;
    logic [NB-1:0]      nb_in;
    logic               last;
  } job_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] r,
                                                   input int unsigned maxv);
    logic [SIZE_W-1:0] res;
    res = r;
    if (r == '0) begin
      res = {{(SIZE_W-1){1'b0}}, 1'b1};
    end else if (32'(r) > maxv) begin
      res = SIZE_W'(maxv);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: sv/vme_front.sv
// Front end: accepts items, clears samples, keeps the value and flag stores and
// issues the reads for each result. Depends on vme_pkg.
`default_nettype none

module vme_front import vme_pkg::*; #(
  parameter int unsigned MAX_X = DEF_MAX_X,
  parameter int unsigned MAX_Y = DEF_MAX_Y,
  parameter int unsigned MAX_Z = DEF_MAX_Z
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [SIZE_W-1:0]             size_x_i,
  input  wire logic [SIZE_W-1:0]             size_y_i,
  input  wire logic [SIZE_W-1:0]             size_z_i,
  input  wire logic                          cfg_wr_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          opcode_i,
  input  wire logic signed [31:0]            sample_i,
  input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count_i,
  output logic                               job_valid_o,
  output job_t                               job_o
);

  localparam int unsigned VD  = MAX_X * MAX_Y + MAX_X;
  localparam int unsigned FD  = 2 * MAX_X * MAX_Y + MAX_X;
  localparam int unsigned VAW = $clog2(VD);
  localparam int unsigned FAW = $clog2(FD);
  localparam int unsigned PW  = $clog2(MAX_X * MAX_Y * MAX_Z + MAX_X * MAX_Y + MAX_X + 1);
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);

  logic [SIZE_W-1:0] sx, sy, sz;
  logic [2*SIZE_W-1:0] prod_xy;
  logic [PW+SIZE_W-1:0] prod_tot;
  logic [PW-1:0] plane_q, total_q, lag_q;
  logic [1:0] settle_q, settle_d;

  logic [PW-1:0] in_pos_q, in_pos_d, out_pos_q, out_pos_d;
  logic [VAW-1:0] ivp_q, ivp_d, ovp_q, ovp_d;
  logic [FAW-1:0] ifp_q, ifp_d, ofp_q, ofp_d;
  logic [SIZE_W-1:0] ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;
  logic s1_valid_q, s1_last_q;
  logic [NB-1:0] s1_in_q;

  logic accept, push, emit, last;
  logic signed [31:0] cleared;
  logic [FAW-1:0] faddr [NB];
  logic [FAW:0] ext_p, ext_x, ext_pl, ofp_e;
  logic [NB-1:0] nb_in, fdata;
  logic [31:0] vdata_q;
  logic [CW:0] q_used;

  assign sx = clamp_size(size_x_i, MAX_X);
  assign sy = clamp_size(size_y_i, MAX_Y);
  assign sz = clamp_size(size_z_i, MAX_Z);

  // Geometry is registered: the plane size first, then the volume size and lag from it.
  assign prod_xy  = {{SIZE_W{1'b0}}, sx} * {{SIZE_W{1'b0}}, sy};
  assign prod_tot = {{SIZE_W{1'b0}}, plane_q} * {{PW{1'b0}}, sz};

  always_ff @(posedge clk_i) begin
    plane_q <= PW'(prod_xy);
    total_q <= PW'(prod_tot);
    lag_q   <= plane_q + PW'(sx);
  end

  assign q_used     = (CW+1)'(q_count_i) + (CW+1)'(s1_valid_q);
  assign in_ready_o = (settle_q == 2'd0) && (q_used < (CW+1)'(QUEUE_DEPTH));
  assign accept     = in_valid_i && in_ready_o;

  assign cleared = (sample_i > 32'sd0 && sample_i < ONE_Q16) ? 32'sd0 : sample_i;

  always_comb begin
    push = 1'b0;
    emit = 1'b0;
    if (accept) begin
      if (!opcode_i && in_pos_q < total_q) begin
        push = 1'b1;
        emit = (in_pos_q >= lag_q);
      end else if (in_pos_q == total_q && out_pos_q < total_q) begin
        emit = 1'b1;
      end
    end
  end

  assign last = (out_pos_q == total_q - PW'(1));

  always_comb begin
    settle_d  = (settle_q != 2'd0) ? settle_q - 2'd1 : settle_q;
    in_pos_d  = in_pos_q;
    out_pos_d = out_pos_q;
    ivp_d = ivp_q;
    ifp_d = ifp_q;
    ovp_d = ovp_q;
    ofp_d = ofp_q;
    ox_d = ox_q;
    oy_d = oy_q;
    oz_d = oz_q;
    if (push) begin
      in_pos_d = in_pos_q + PW'(1);
      ivp_d = (ivp_q == VAW'(VD - 1)) ? '0 : ivp_q + VAW'(1);
      ifp_d = (ifp_q == FAW'(FD - 1)) ? '0 : ifp_q + FAW'(1);
    end
    if (emit) begin
      out_pos_d = out_pos_q + PW'(1);
      ovp_d = (ovp_q == VAW'(VD - 1)) ? '0 : ovp_q + VAW'(1);
      ofp_d = (ofp_q == FAW'(FD - 1)) ? '0 : ofp_q + FAW'(1);
      if (ox_q == sx - SIZE_W'(1)) begin
        ox_d = '0;
        if (oy_q == sy - SIZE_W'(1)) begin
          oy_d = '0;
          oz_d = oz_q + SIZE_W'(1);
        end else begin
          oy_d = oy_q + SIZE_W'(1);
        end
      end else begin
        ox_d = ox_q + SIZE_W'(1);
      end
    end
    if (cfg_wr_i || (emit && last)) begin
      in_pos_d  = '0;
      out_pos_d = '0;
      ivp_d = '0;
      ifp_d = '0;
      ovp_d = '0;
      ofp_d = '0;
      ox_d = '0;
      oy_d = '0;
      oz_d = '0;
    end
    if (cfg_wr_i) begin
      settle_d = 2'd2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q   <= 2'd2;
      in_pos_q   <= '0;
      out_pos_q  <= '0;
      ivp_q      <= '0;
      ifp_q      <= '0;
      ovp_q      <= '0;
      ofp_q      <= '0;
      ox_q       <= '0;
      oy_q       <= '0;
      oz_q       <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      settle_q   <= settle_d;
      in_pos_q   <= in_pos_d;
      out_pos_q  <= out_pos_d;
      ivp_q      <= ivp_d;
      ifp_q      <= ifp_d;
      ovp_q      <= ovp_d;
      ofp_q      <= ofp_d;
      ox_q       <= ox_d;
      oy_q       <= oy_d;
      oz_q       <= oz_d;
      s1_valid_q <= emit;
    end
  end

  // Neighbor addresses around the output position, wrapped into the flag store.
  assign ofp_e  = {1'b0, ofp_q};
  assign ext_p  = (FAW+1)'(1);
  assign ext_x  = (FAW+1)'(sx);
  assign ext_pl = (FAW+1)'(plane_q);

  function automatic logic [FAW-1:0] add_wrap(input logic [FAW:0] a, input logic [FAW:0] m);
    logic [FAW:0] s;
    s = a + m;
    if (s >= (FAW+1)'(FD)) begin
      s = s - (FAW+1)'(FD);
    end
    return s[FAW-1:0];
  endfunction

  function automatic logic [FAW-1:0] sub_wrap(input logic [FAW:0] a, input logic [FAW:0] m);
    logic [FAW:0] s;
    s = a - m;
    if (a < m) begin
      s = s + (FAW+1)'(FD);
    end
    return s[FAW-1:0];
  endfunction

  assign faddr[NB_XM] = sub_wrap(ofp_e, ext_p);
  assign faddr[NB_XP] = add_wrap(ofp_e, ext_p);
  assign faddr[NB_YM] = sub_wrap(ofp_e, ext_x);
  assign faddr[NB_YP] = add_wrap(ofp_e, ext_x);
  assign faddr[NB_ZM] = sub_wrap(ofp_e, ext_pl);
  assign faddr[NB_ZP] = add_wrap(ofp_e, ext_pl);

  assign nb_in[NB_XM] = (ox_q != '0);
  assign nb_in[NB_XP] = (ox_q != sx - SIZE_W'(1));
  assign nb_in[NB_YM] = (oy_q != '0);
  assign nb_in[NB_YP] = (oy_q != sy - SIZE_W'(1));
  assign nb_in[NB_ZM] = (oz_q != '0);
  assign nb_in[NB_ZP] = (oz_q != sz - SIZE_W'(1));

  // Reads see the old contents when they hit the slot being written.
  logic [31:0] vmem [VD];

  always_ff @(posedge clk_i) begin
    if (push) begin
      vmem[ivp_q] <= cleared;
    end
    vdata_q <= vmem[ovp_q];
  end

  // One copy of the zero-flag store per neighbor read.
  for (genvar g = 0; g < NB; g++) begin : g_flag
    logic fmem [FD];
    logic fq;
    always_ff @(posedge clk_i) begin
      if (push) begin
        fmem[ifp_q] <= (cleared == 32'sd0);
      end
      fq <= fmem[faddr[g]];
    end
    assign fdata[g] = fq;
  end

  always_ff @(posedge clk_i) begin
    s1_in_q   <= nb_in;
    s1_last_q <= last;
  end

  assign job_valid_o   = s1_valid_q;
  assign job_o.value   = vdata_q;
  assign job_o.nb_zero = fdata;
  assign job_o.nb_in   = s1_in_q;
  assign job_o.last    = s1_last_q;

  a_job_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o |-> $past(in_valid_i && in_ready_o))
    else $error("result job without an accepted item");

  a_in_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (settle_q == 2'd0) |-> (in_pos_q <= total_q))
    else $error("input position beyond the volume");

  a_out_behind_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_pos_q <= in_pos_q)
    else $error("output position ahead of input position");

endmodule

`default_nettype wire

FILE: sv/vme_queue.sv
// Short queue of result jobs between the front end and the output stage.
// Depends on vme_pkg.
`default_nettype none

module vme_queue import vme_pkg::*; (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push_i,
  input  wire job_t                             job_i,
  input  wire logic                             pop_i,
  output logic                                  valid_o,
  output job_t                                  job_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]      count_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  job_t entry_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      count_q <= count_q + CW'(push_i) - CW'(pop_i);
    end
  end

  assign valid_o = (count_q != '0);
  assign job_o   = entry_q[rd_q];
  assign count_o = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < CW'(QUEUE_DEPTH)))
    else $error("job queue overflow");

endmodule

`default_nettype wire

FILE: sv/vme_back.sv
// Output stage: applies the erosion rule to a queued job and holds the beat
// in the output register. Depends on vme_pkg.
`default_nettype none

module vme_back import vme_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        job_valid_i,
  input  wire job_t        job_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [31:0] voxel_value_o,
  output logic             volume_end_o
);

  logic out_valid_q;
  logic signed [31:0] value_q, value_d;
  logic end_q;
  logic eroded;

  assign eroded  = (job_i.value == ONE_Q16) && ((job_i.nb_zero & job_i.nb_in) != '0);
  assign value_d = eroded ? 32'sd0 : job_i.value;
  assign pop_o   = job_valid_i && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      value_q <= value_d;
      end_q   <= job_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign voxel_value_o = value_q;
  assign volume_end_o  = end_q;

endmodule

`default_nettype wire

FILE: sv/volume_mask_erode_6n.sv
// Top level of the 3D 6-neighbor mask erosion block: configuration registers
// and the front end, job queue and output stage. Depends on vme_pkg.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  opcode_i, sample_i
//   out      output     out_valid_o/out_ready_i voxel_value_o, volume_end_o
//   cfg      input      psel/penable/pwrite    paddr, pwdata, prdata
//
// One item is accepted per cycle while in_ready_o is high; a result passes the
// front-end read stage, job queue and output register, and lags its voxel by
// one plane plus one row of items (drain items release the tail).
// After reset and after every size write the input is held off while the plane
// size, volume size and lag products settle.
// A stalled output fills the four-entry job queue before the input stalls.
`default_nettype none

module volume_mask_erode_6n import vme_pkg::*; #(
  parameter int unsigned MAX_X = DEF_MAX_X,
  parameter int unsigned MAX_Y = DEF_MAX_Y,
  parameter int unsigned MAX_Z = DEF_MAX_Z
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               opcode_i,
  input  wire logic signed [31:0] sample_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      voxel_value_o,
  output logic                    volume_end_o
);

  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic wr, cfg_wr;
  logic [1:0] idx;
  logic job_valid, q_valid, pop;
  job_t job, q_job;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;

  always_comb begin
    cfg_wr = 1'b0;
    prdata = '0;
    unique case (idx)
      REG_SIZE_X: begin
        cfg_wr = wr;
        prdata = 32'(size_x_q);
      end
      REG_SIZE_Y: begin
        cfg_wr = wr;
        prdata = 32'(size_y_q);
      end
      REG_SIZE_Z: begin
        cfg_wr = wr;
        prdata = 32'(size_z_q);
      end
      default: begin
        cfg_wr = 1'b0;
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= RST_SIZE_X;
      size_y_q <= RST_SIZE_Y;
      size_z_q <= RST_SIZE_Z;
    end else if (cfg_wr) begin
      if (idx == REG_SIZE_X) begin
        size_x_q <= pwdata[SIZE_W-1:0];
      end
      if (idx == REG_SIZE_Y) begin
        size_y_q <= pwdata[SIZE_W-1:0];
      end
      if (idx == REG_SIZE_Z) begin
        size_z_q <= pwdata[SIZE_W-1:0];
      end
    end
  end

  vme_front #(
    .MAX_X(MAX_X),
    .MAX_Y(MAX_Y),
    .MAX_Z(MAX_Z)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .size_x_i    (size_x_q),
    .size_y_i    (size_y_q),
    .size_z_i    (size_z_q),
    .cfg_wr_i    (cfg_wr),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .sample_i    (sample_i),
    .q_count_i   (q_count),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  vme_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .job_i   (job),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (q_job),
    .count_o (q_count)
  );

  vme_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (q_valid),
    .job_i         (q_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .voxel_value_o (voxel_value_o),
    .volume_end_o  (volume_end_o)
  );

endmodule

`default_nettype wire

FILE: verif/volume_mask_erode_6n_tb.sv
// Self-checking testbench for the 3D 6-neighbor mask erosion block.
// Streams small volumes under random idling and checks each output beat
// against a voxel-level erosion predictor. Depends on vme_pkg and the RTL.
`default_nettype none

module volume_mask_erode_6n_tb;
  import vme_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VAL_DEPTH  = DEF_MAX_X * DEF_MAX_Y + DEF_MAX_X;
  localparam int unsigned FLAG_DEPTH = 2 * DEF_MAX_X * DEF_MAX_Y + DEF_MAX_X;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned TARGET_ITEMS = 1750;
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } voxel_t;

  // Predicts eroded voxels from the accepted input beats.
  class erosion_tracker;
    logic [SIZE_W-1:0] size_reg [3];
    logic [31:0] values [VAL_DEPTH];
    bit          zero_flags [FLAG_DEPTH];
    int unsigned in_pos, out_pos;
    voxel_t      expected_voxels[$];
    int unsigned errors;

    function new();
      size_reg[REG_SIZE_X] = RST_SIZE_X;
      size_reg[REG_SIZE_Y] = RST_SIZE_Y;
      size_reg[REG_SIZE_Z] = RST_SIZE_Z;
      in_pos = 0;
      out_pos = 0;
      errors = 0;
    endfunction

    function int unsigned dim(int idx, int unsigned maxv);
      int unsigned r;
      r = 32'(size_reg[idx]);
      if (r == 0) return 1;
      if (r > maxv) return maxv;
      return r;
    endfunction

    function void write_size(logic [1:0] idx, logic [31:0] data);
      size_reg[idx] = data[SIZE_W-1:0];
      in_pos = 0;
      out_pos = 0;
    endfunction

    function int unsigned volume_total();
      return dim(REG_SIZE_X, DEF_MAX_X) * dim(REG_SIZE_Y, DEF_MAX_Y) *
             dim(REG_SIZE_Z, DEF_MAX_Z);
    endfunction

    function bit zero_at(int unsigned pos);
      return zero_flags[pos % FLAG_DEPTH];
    endfunction

    function void release_voxel();
      int unsigned sx, sy, sz, plane, total, p, x, y, z;
      logic [31:0] v;
      bit hit;
      voxel_t e;
      sx = dim(REG_SIZE_X, DEF_MAX_X);
      sy = dim(REG_SIZE_Y, DEF_MAX_Y);
      sz = dim(REG_SIZE_Z, DEF_MAX_Z);
      plane = sx * sy;
      total = plane * sz;
      p = out_pos;
      x = p % sx;
      y = (p / sx) % sy;
      z = p / plane;
      v = values[p % VAL_DEPTH];
      hit = 0;
      if (v == ONE_Q16) begin
        if (x > 0 && zero_at(p - 1)) hit = 1;
        if (x + 1 < sx && zero_at(p + 1)) hit = 1;
        if (y > 0 && zero_at(p - sx)) hit = 1;
        if (y + 1 < sy && zero_at(p + sx)) hit = 1;
        if (z > 0 && zero_at(p - plane)) hit = 1;
        if (z + 1 < sz && zero_at(p + plane)) hit = 1;
        if (hit) v = '0;
      end
      e.value = v;
      e.last = (p + 1 >= total);
      expected_voxels.push_back(e);
      if (e.last) begin
        in_pos = 0;
        out_pos = 0;
      end else begin
        out_pos = p + 1;
      end
    endfunction

    function void note_input(logic op, logic signed [31:0] s);
      int unsigned sx, sy, total, lag;
      logic [31:0] cleared;
      sx = dim(REG_SIZE_X, DEF_MAX_X);
      sy = dim(REG_SIZE_Y, DEF_MAX_Y);
      total = volume_total();
      lag = sx * sy + sx;
      if (op == OP_PUSH && in_pos < total) begin
        cleared = (s > 0 && s < ONE_Q16) ? 32'd0 : s;
        if (in_pos - out_pos >= lag) release_voxel();
        values[in_pos % VAL_DEPTH] = cleared;
        zero_flags[in_pos % FLAG_DEPTH] = (cleared == 0);
        in_pos++;
      end else if (in_pos == total && out_pos < total) begin
        release_voxel();
      end
    endfunction

    function void check_voxel(logic [31:0] value, logic last);
      voxel_t e;
      if (expected_voxels.size() == 0) begin
        $error("output beat with nothing expected: value %h end %b", value, last);
        errors++;
        return;
      end
      e = expected_voxels.pop_front();
      if (value !== e.value) begin
        $error("voxel_value: expected %h, got %h", e.value, value);
        errors++;
      end
      if (last !== e.last) begin
        $error("volume_end: expected %b, got %b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic opcode_i = 1'b0;
  logic signed [31:0] sample_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] voxel_value_o;
  logic volume_end_o;

  erosion_tracker tracker = new();
  int unsigned idle_pct = 16;
  int unsigned stall_pct = 50;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;

  volume_mask_erode_6n dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_voxel(voxel_value_o, volume_end_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Valid is left high after a beat; the next call decides whether to drop it.
  task automatic send_beat(logic op, logic signed [31:0] s);
    if (items_sent > 2 * TARGET_ITEMS / 3) begin
      idle_pct = 0;
      stall_pct = 0;
    end else if (items_sent > TARGET_ITEMS / 3) begin
      idle_pct = 50;
      stall_pct = 16;
    end
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    sample_i <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_input(op, s);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.expected_voxels.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_size(logic [1:0] idx, logic [6:0] val);
    logic [31:0] data;
    data = {$urandom_range(0, 1) ? $urandom() : 32'd0};
    data[6:0] = val;
    drain_results();
    repeat (8) @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    tracker.write_size(idx, data);
  endtask

  task automatic set_volume(logic [6:0] x, logic [6:0] y, logic [6:0] z);
    write_size(REG_SIZE_X, x);
    write_size(REG_SIZE_Y, y);
    write_size(REG_SIZE_Z, z);
  endtask

  function automatic logic signed [31:0] mask_sample();
    case ($urandom_range(0, 9))
      5: return 32'sd0;
      6: return $urandom_range(1, 65535);
      7: return $urandom();
      8: return -$signed(32'($urandom_range(1, 200000)));
      default: return ONE_Q16;
    endcase
  endfunction

  // One volume with random content; a partial one stops early and leaves
  // the rest to be abandoned by the next size write.
  task automatic stream_volume(bit partial, bit pause_midway);
    int unsigned total, stop;
    total = tracker.volume_total();
    stop = partial ? $urandom_range(1, total) - 1 : total;
    for (int unsigned i = 0; i < stop; i++) begin
      if ($urandom_range(0, 99) < 4) send_beat(OP_DRAIN, $urandom());
      if (pause_midway && i == stop / 2) drain_results();
      send_beat(OP_PUSH, mask_sample());
    end
    if (partial) return;
    while (tracker.out_pos != 0 || tracker.in_pos != 0) begin
      if ($urandom_range(0, 99) < 20) send_beat(OP_PUSH, $urandom());
      else send_beat(OP_DRAIN, $urandom());
    end
    if ($urandom_range(0, 1)) send_beat(OP_DRAIN, $urandom());
  endtask

  initial begin
    logic signed [31:0] corner [18] = '{32'sh80000000, 32'sh7fffffff, 32'sd1, 32'sd65535,
      32'sd65536, 32'sd65537, -32'sd1, 32'sd0, 32'sd65536, 32'sd65536, 32'sd65536,
      32'sd65536, 32'sd32768, 32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes and fractional clearing in a 3x3x2 volume.
    set_volume(7'd3, 7'd3, 7'd2);
    send_beat(OP_DRAIN, 32'sd0);
    foreach (corner[i]) send_beat(OP_PUSH, corner[i]);
    repeat (5) send_beat(OP_DRAIN, 32'sd0);
    send_beat(OP_PUSH, ONE_Q16);
    send_beat(OP_PUSH, ONE_Q16);

    // Size extremes: zero acts as one, above the limit acts as the limit.
    set_volume(7'd127, 7'd1, 7'd2);
    stream_volume(0, 1);
    set_volume(7'd1, 7'd64, 7'd1);
    stream_volume(0, 0);
    set_volume(7'd0, 7'd0, 7'd127);
    stream_volume(0, 0);
    set_volume(7'd64, 7'd2, 7'd2);
    stream_volume(1, 0);
    set_volume(7'd1, 7'd1, 7'd1);
    stream_volume(0, 0);
    stream_volume(0, 0);

    while (items_sent < TARGET_ITEMS) begin
      set_volume(7'($urandom_range(1, 9)), 7'($urandom_range(1, 7)),
                 7'($urandom_range(1, 6)));
      repeat ($urandom_range(1, 2)) stream_volume($urandom_range(0, 7) == 0, 0);
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.expected_voxels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
